/* rtl/line_pixel_walker_assert.svh */
// Assertion helpers shared by the line walker RTL.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef LINE_PIXEL_WALKER_ASSERT_SVH
`define LINE_PIXEL_WALKER_ASSERT_SVH

// Property must hold at every sampled edge.
`define LPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen.
`define LPW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/lpw_pkg.sv */
package lpw_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned DIM_BITS       = 11;
  localparam int unsigned COLOR_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS   = 2;

  localparam logic [DIM_BITS-1:0] SCREEN_W_RST = 11'd320;
  localparam logic [DIM_BITS-1:0] SCREEN_H_RST = 11'd480;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } lpw_cfg_idx_e;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } lpw_func_e;

  // Decoded command flags handed from front to back.
  typedef struct packed {
    logic start;
    logic x_major;
    logic x_neg;
    logic y_neg;
  } lpw_ctl_t;

  localparam int unsigned CTL_BITS = $bits(lpw_ctl_t);

endpackage

/* rtl/lpw_fifo.sv */
`include "line_pixel_walker_assert.svh"

module lpw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `LPW_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue count above depth")
  `LPW_ASSERT(a_ptr_empty, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q), "pointers apart while empty")

endmodule

/* rtl/lpw_front.sv */
module lpw_front import lpw_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item intake
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         func_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_BITS-1:0]        line_color_i,
  // decoded command to the walker
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output lpw_ctl_t                     cmd_ctl_o,
  output logic [COORD_BITS-1:0]        cmd_x_o,
  output logic [COORD_BITS-1:0]        cmd_y_o,
  output logic [COORD_BITS-1:0]        cmd_major_o,
  output logic [COORD_BITS-1:0]        cmd_minor_o,
  output logic [COLOR_BITS-1:0]        cmd_color_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned QW = CTL_BITS + 4 * C + COLOR_BITS;

  logic signed [C:0] dxp, dxn, dyp, dyn;
  logic              x_gt, y_gt;
  logic [C-1:0]      dx, dy;
  lpw_ctl_t          ctl;
  logic [C-1:0]      x0, y0, major, minor;
  logic [QW-1:0]     q_wdata, q_rdata;
  logic              q_empty;

  // absolute deltas, both differences side by side
  assign dxp  = {end_x_i[C-1], end_x_i} - {start_x_i[C-1], start_x_i};
  assign dxn  = {start_x_i[C-1], start_x_i} - {end_x_i[C-1], end_x_i};
  assign dyp  = {end_y_i[C-1], end_y_i} - {start_y_i[C-1], start_y_i};
  assign dyn  = {start_y_i[C-1], start_y_i} - {end_y_i[C-1], end_y_i};
  assign x_gt = end_x_i > start_x_i;
  assign y_gt = end_y_i > start_y_i;
  assign dx   = x_gt ? dxp[C-1:0] : dxn[C-1:0];
  assign dy   = y_gt ? dyp[C-1:0] : dyn[C-1:0];

  always_comb begin
    ctl.start   = (func_i == FUNC_START);
    ctl.x_neg   = ~x_gt;
    ctl.y_neg   = ~y_gt;
    ctl.x_major = 1'b0;
    x0          = start_x_i;
    y0          = start_y_i;
    priority if (start_y_i == end_y_i) begin
      // horizontal (or single point): walk up from the smaller x
      x0          = x_gt ? start_x_i : end_x_i;
      ctl.x_neg   = 1'b0;
      ctl.x_major = 1'b1;
    end else if (start_x_i == end_x_i) begin
      // vertical: walk up from the smaller y
      y0          = y_gt ? start_y_i : end_y_i;
      ctl.y_neg   = 1'b0;
      ctl.x_major = 1'b0;
    end else begin
      ctl.x_major = dx > dy;
    end
    major = ctl.x_major ? dx : dy;
    minor = ctl.x_major ? dy : dx;
  end

  assign q_wdata = {ctl, x0, y0, major, minor, line_color_i};

  lpw_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (q_wdata),
    .full_o  (full_o),
    .pop_i   (cmd_ready_i),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign cmd_valid_o = ~q_empty;
  assign {cmd_ctl_o, cmd_x_o, cmd_y_o, cmd_major_o, cmd_minor_o, cmd_color_o} = q_rdata;

endmodule

/* rtl/lpw_back.sv */
`include "line_pixel_walker_assert.svh"

module lpw_back import lpw_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // decoded commands
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  lpw_ctl_t                     cmd_ctl_i,
  input  logic [COORD_BITS-1:0]        cmd_x_i,
  input  logic [COORD_BITS-1:0]        cmd_y_i,
  input  logic [COORD_BITS-1:0]        cmd_major_i,
  input  logic [COORD_BITS-1:0]        cmd_minor_i,
  input  logic [COLOR_BITS-1:0]        cmd_color_i,
  // screen size registers
  input  logic                         cfg_valid_i,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [DIM_BITS-1:0]          cfg_data_i,
  // pixel results
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic [COLOR_BITS-1:0]        pixel_color_o,
  output logic                         on_screen_o,
  output logic                         last_o
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned EW   = C + 2;
  localparam int unsigned CMPW = (C > DIM_BITS) ? C : DIM_BITS;
  localparam int unsigned OW   = 2 * C + COLOR_BITS + 2;

  logic [DIM_BITS-1:0]  width_q, height_q;

  logic                 active_q, active_d;
  logic [C:0]           pl_q, pl_d;
  logic [C-1:0]         x_q, x_d, y_q, y_d;
  logic signed [EW-1:0] err_q, err_d, m2_q, m2_d, diff2_q, diff2_d;
  logic                 xmaj_q, xmaj_d, xneg_q, xneg_d, yneg_q, yneg_d;
  logic [COLOR_BITS-1:0] color_q, color_d;

  logic                 need_out, take_cmd, out_push, out_full;
  logic                 on, fin;
  logic [C-1:0]         x_step, y_step;
  logic signed [EW-1:0] e_add, e_sub;
  logic [OW-1:0]        out_wdata, out_rdata;

  // config writes are to come only while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_W_RST;
      height_q <= SCREEN_H_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a step on an active line needs a slot in the result queue
  assign need_out    = ~cmd_ctl_i.start & active_q;
  assign cmd_ready_o = ~need_out | ~out_full;
  assign take_cmd    = cmd_valid_i & cmd_ready_o;
  assign out_push    = take_cmd & need_out;

  assign on = ~x_q[C-1] & ~y_q[C-1] &
              (CMPW'($unsigned(x_q)) < CMPW'(width_q)) &
              (CMPW'($unsigned(y_q)) < CMPW'(height_q));
  assign fin = (pl_q <= (C+1)'(1));

  assign x_step = xneg_q ? {C{1'b1}} : C'(1);
  assign y_step = yneg_q ? {C{1'b1}} : C'(1);
  assign e_add  = err_q + m2_q;
  assign e_sub  = err_q + diff2_q;

  always_comb begin
    active_d = active_q;
    pl_d     = pl_q;
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    m2_d     = m2_q;
    diff2_d  = diff2_q;
    xmaj_d   = xmaj_q;
    xneg_d   = xneg_q;
    yneg_d   = yneg_q;
    color_d  = color_q;
    if (take_cmd) begin
      if (cmd_ctl_i.start) begin
        active_d = 1'b1;
        pl_d     = {1'b0, cmd_major_i} + (C+1)'(1);
        x_d      = cmd_x_i;
        y_d      = cmd_y_i;
        err_d    = -$signed({2'b00, cmd_major_i});
        m2_d     = $signed({1'b0, cmd_minor_i, 1'b0});
        diff2_d  = $signed({1'b0, cmd_minor_i, 1'b0}) - $signed({1'b0, cmd_major_i, 1'b0});
        xmaj_d   = cmd_ctl_i.x_major;
        xneg_d   = cmd_ctl_i.x_neg;
        yneg_d   = cmd_ctl_i.y_neg;
        color_d  = cmd_color_i;
      end else if (active_q) begin
        if (fin) begin
          active_d = 1'b0;
          pl_d     = '0;
        end else begin
          pl_d = pl_q - (C+1)'(1);
          // major axis always moves, minor when the error turns non-negative
          if (xmaj_q) begin
            x_d = x_q + x_step;
          end else begin
            y_d = y_q + y_step;
          end
          if (!e_add[EW-1]) begin
            err_d = e_sub;
            if (xmaj_q) begin
              y_d = y_q + y_step;
            end else begin
              x_d = x_q + x_step;
            end
          end else begin
            err_d = e_add;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pl_q     <= '0;
    end else begin
      active_q <= active_d;
      pl_q     <= pl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    err_q   <= err_d;
    m2_q    <= m2_d;
    diff2_q <= diff2_d;
    xmaj_q  <= xmaj_d;
    xneg_q  <= xneg_d;
    yneg_q  <= yneg_d;
    color_q <= color_d;
  end

  assign out_wdata = {x_q, y_q, color_q, on, fin};

  lpw_fifo #(
    .WIDTH (OW),
    .DEPTH (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .rdata_o (out_rdata),
    .empty_o (empty_o)
  );

  assign {pixel_x_o, pixel_y_o, pixel_color_o, on_screen_o, last_o} = out_rdata;

  `LPW_ASSERT(a_active_has_pixels, active_q |-> (pl_q != '0), "active line with no pixels left")
  `LPW_ASSERT(a_last_ends_walk, (out_push && fin) |=> !active_q, "walk still active after last")
  `LPW_ASSERT_NEVER(a_push_overflow, out_push && out_full, "result pushed into full queue")

endmodule

/* rtl/line_pixel_walker.sv */
// Raster line walker: one start item loads a line, each step item yields
// the next pixel of it (Bresenham stepping, flagged against screen size).
// Input side is a queue: an item transfers when push is high and full low.
// func_i = start loads endpoints and color and drops any line in progress;
// func_i = step yields one pixel while a line is active, nothing otherwise.
// Result side is a queue: the oldest pixel sits on the pixel ports while
// empty is low and transfers when pop is high.
// Path: a step item passes the command queue, then the walker writes
// its pixel into the result queue.
// Throughput: one item per clock while the result queue has room; the
// walker's add/compare update sets the pace.
// Receiver stall: the 2-entry result queue fills, the walker holds, then
// the 2-entry command queue fills and full rises. No item is lost.
// Config: cfg_valid_i/cfg_index_i/cfg_data_i set screen width (index 0)
// and height (index 1); cfg_ready_o is always high; other indexes ignored.
// Write only while no line work is pending.
// Reset: queues empty, no line active, screen 320 x 480.
module line_pixel_walker import lpw_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item input
  input  logic                         push,
  output logic                         full,
  input  logic                         func_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_BITS-1:0]        line_color_i,
  // pixel output
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic [COLOR_BITS-1:0]        pixel_color_o,
  output logic                         on_screen_o,
  output logic                         last_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [DIM_BITS-1:0]          cfg_data_i
);

  // front -> back command link
  logic                  cmd_valid, cmd_ready;
  lpw_ctl_t              cmd_ctl;
  logic [COORD_BITS-1:0] cmd_x, cmd_y, cmd_major, cmd_minor;
  logic [COLOR_BITS-1:0] cmd_color;

  // registers are plain flops, always writable
  assign cfg_ready_o = 1'b1;

  // Front: takes items, works out deltas, direction and major axis,
  // and queues a decoded command.
  lpw_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .func_i       (func_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .line_color_i (line_color_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_ctl_o    (cmd_ctl),
    .cmd_x_o      (cmd_x),
    .cmd_y_o      (cmd_y),
    .cmd_major_o  (cmd_major),
    .cmd_minor_o  (cmd_minor),
    .cmd_color_o  (cmd_color)
  );

  // Back: holds the walk state, one command per clock, pixels into the
  // result queue. Holds off only when a pixel has no room.
  lpw_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_ctl_i     (cmd_ctl),
    .cmd_x_i       (cmd_x),
    .cmd_y_i       (cmd_y),
    .cmd_major_i   (cmd_major),
    .cmd_minor_i   (cmd_minor),
    .cmd_color_i   (cmd_color),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pop_i         (pop),
    .empty_o       (empty),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .on_screen_o   (on_screen_o),
    .last_o        (last_o)
  );

endmodule
